// ===== sv/ffrp_pkg.sv =====
// ----------------------------------------------------------------------------
// ffrp_pkg
// Types, constants and helper functions for the FASTA/FASTQ record parser.
// ----------------------------------------------------------------------------
package ffrp_pkg;

  localparam int unsigned LengthBits = 24;
  localparam int unsigned LenOutW    = 24;
  localparam int unsigned CharW      = 8;

  localparam logic [LengthBits-1:0] CountMax = {LengthBits{1'b1}};

  localparam logic [CharW-1:0] ChGt      = 8'd62;
  localparam logic [CharW-1:0] ChAt      = 8'd64;
  localparam logic [CharW-1:0] ChPlus    = 8'd43;
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChSpace   = 8'd32;
  localparam logic [CharW-1:0] ChTab     = 8'd9;
  localparam logic [CharW-1:0] ChCr      = 8'd13;
  localparam logic [CharW-1:0] GraphLo   = 8'd33;
  localparam logic [CharW-1:0] GraphHi   = 8'd126;
  localparam logic [CharW-1:0] QualHi    = 8'd127;

  typedef enum logic [2:0] {
    PhSeek      = 3'd0,
    PhNameFirst = 3'd1,
    PhName      = 3'd2,
    PhComment   = 3'd3,
    PhSeq       = 3'd4,
    PhPlus      = 3'd5,
    PhQual      = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KindName    = 3'd0,
    KindComment = 3'd1,
    KindSeq     = 3'd2,
    KindQual    = 3'd3,
    KindRecord  = 3'd4,
    KindStream  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    StFasta    = 2'd0,
    StFastq    = 2'd1,
    StTrunc    = 2'd2,
    StOverflow = 2'd3
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [CharW-1:0]   char_value;
    status_e            status;
    logic [LenOutW-1:0] seq_length;
    logic               end_of_stream;
  } result_t;

  function automatic logic is_space(logic [CharW-1:0] b);
    return (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

  function automatic result_t make_char(kind_e kind, logic [CharW-1:0] b);
    result_t r;
    r.kind          = kind;
    r.char_value    = b;
    r.status        = StFasta;
    r.seq_length    = '0;
    r.end_of_stream = 1'b0;
    return r;
  endfunction

  function automatic result_t make_record(status_e st, logic ovf,
                                          logic [LengthBits-1:0] len, logic eos);
    result_t r;
    r.kind          = KindRecord;
    r.char_value    = '0;
    r.status        = ovf ? StOverflow : st;
    r.seq_length    = LenOutW'(len);
    r.end_of_stream = eos;
    return r;
  endfunction

  function automatic result_t make_stream_end();
    result_t r;
    r.kind          = KindStream;
    r.char_value    = '0;
    r.status        = StFasta;
    r.seq_length    = '0;
    r.end_of_stream = 1'b1;
    return r;
  endfunction

endpackage

// ===== sv/fasta_fastq_record_parser.sv =====
// ----------------------------------------------------------------------------
// fasta_fastq_record_parser
// Byte-stream parser that tags FASTA/FASTQ name, comment, sequence and
// quality characters and closes each record with a status and a length.
// ----------------------------------------------------------------------------
// The parser accepts one item per clock cycle while not held off: each byte
// updates the parse phase and the two length counters, and any result goes
// into an output register backed by a one-entry skid stage, so input is only
// held off while both of those hold an untaken result. A result is registered
// in the output register, or in the skid stage while that one is not taken.
module fasta_fastq_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
  input  logic        s_axis_tlast,  // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // char_value[7:0], status[9:8],
                                     // seq_length[33:10], zero fill[39:34]
  output logic [2:0]  m_axis_tuser,  // kind[2:0]
  output logic        m_axis_tlast   // end_of_stream
);

  localparam int unsigned W = ffrp_pkg::LengthBits;

  ffrp_pkg::phase_e  phase_q, phase_d;
  logic [W-1:0]      seq_count_q, seq_count_d;
  logic [W-1:0]      qual_count_q, qual_count_d;
  logic              ovf_q, ovf_d;

  ffrp_pkg::result_t res;
  logic              res_valid;

  ffrp_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  logic              accept, take;
  logic [7:0]        b;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = out_valid_q && m_axis_tready;

  always_comb begin
    phase_d      = phase_q;
    seq_count_d  = seq_count_q;
    qual_count_d = qual_count_q;
    ovf_d        = ovf_q;
    res          = ffrp_pkg::make_stream_end();
    res_valid    = 1'b0;
    if (s_axis_tlast) begin
      res_valid = 1'b1;
      priority if (phase_q == ffrp_pkg::PhSeek || phase_q == ffrp_pkg::PhNameFirst) begin
        res = ffrp_pkg::make_stream_end();
      end else if (phase_q == ffrp_pkg::PhPlus) begin
        res = ffrp_pkg::make_record(ffrp_pkg::StTrunc, ovf_q, seq_count_q, 1'b1);
      end else if (phase_q == ffrp_pkg::PhQual) begin
        res = ffrp_pkg::make_record(
          (qual_count_q < seq_count_q) ? ffrp_pkg::StTrunc : ffrp_pkg::StFastq,
          ovf_q, seq_count_q, 1'b1);
      end else begin
        res = ffrp_pkg::make_record(ffrp_pkg::StFasta, ovf_q, seq_count_q, 1'b1);
      end
      phase_d      = ffrp_pkg::PhSeek;
      seq_count_d  = '0;
      qual_count_d = '0;
      ovf_d        = 1'b0;
    end else begin
      unique case (phase_q)
        ffrp_pkg::PhSeek: begin
          if (b == ffrp_pkg::ChGt || b == ffrp_pkg::ChAt) begin
            phase_d      = ffrp_pkg::PhNameFirst;
            seq_count_d  = '0;
            qual_count_d = '0;
            ovf_d        = 1'b0;
          end
        end
        ffrp_pkg::PhNameFirst, ffrp_pkg::PhName: begin
          if (ffrp_pkg::is_space(b)) begin
            phase_d = (b == ffrp_pkg::ChNewline) ? ffrp_pkg::PhSeq : ffrp_pkg::PhComment;
          end else begin
            phase_d   = ffrp_pkg::PhName;
            res       = ffrp_pkg::make_char(ffrp_pkg::KindName, b);
            res_valid = 1'b1;
          end
        end
        ffrp_pkg::PhComment: begin
          if (b == ffrp_pkg::ChNewline) begin
            phase_d = ffrp_pkg::PhSeq;
          end else begin
            res       = ffrp_pkg::make_char(ffrp_pkg::KindComment, b);
            res_valid = 1'b1;
          end
        end
        ffrp_pkg::PhSeq: begin
          if (b == ffrp_pkg::ChGt || b == ffrp_pkg::ChAt) begin
            phase_d      = ffrp_pkg::PhNameFirst;
            res          = ffrp_pkg::make_record(ffrp_pkg::StFasta, ovf_q, seq_count_q, 1'b0);
            res_valid    = 1'b1;
            seq_count_d  = '0;
            qual_count_d = '0;
            ovf_d        = 1'b0;
          end else if (b == ffrp_pkg::ChPlus) begin
            phase_d = ffrp_pkg::PhPlus;
          end else if (b >= ffrp_pkg::GraphLo && b <= ffrp_pkg::GraphHi) begin
            if (seq_count_q == ffrp_pkg::CountMax) begin
              ovf_d = 1'b1;
            end else begin
              seq_count_d = seq_count_q + 1'b1;
            end
            res       = ffrp_pkg::make_char(ffrp_pkg::KindSeq, b);
            res_valid = 1'b1;
          end
        end
        ffrp_pkg::PhPlus: begin
          if (b == ffrp_pkg::ChNewline) begin
            phase_d = ffrp_pkg::PhQual;
          end
        end
        ffrp_pkg::PhQual: begin
          if (qual_count_q < seq_count_q) begin
            if (b >= ffrp_pkg::GraphLo && b <= ffrp_pkg::QualHi) begin
              if (qual_count_q == ffrp_pkg::CountMax) begin
                ovf_d = 1'b1;
              end else begin
                qual_count_d = qual_count_q + 1'b1;
              end
              res       = ffrp_pkg::make_char(ffrp_pkg::KindQual, b);
              res_valid = 1'b1;
            end
          end else begin
            phase_d      = ffrp_pkg::PhSeek;
            res          = ffrp_pkg::make_record(ffrp_pkg::StFastq, ovf_q, seq_count_q, 1'b0);
            res_valid    = 1'b1;
            seq_count_d  = '0;
            qual_count_d = '0;
            ovf_d        = 1'b0;
          end
        end
        default: begin
          phase_d      = ffrp_pkg::PhSeek;
          seq_count_d  = '0;
          qual_count_d = '0;
          ovf_d        = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ffrp_pkg::PhSeek;
      seq_count_q  <= '0;
      qual_count_q <= '0;
      ovf_q        <= 1'b0;
    end else if (accept) begin
      phase_q      <= phase_d;
      seq_count_q  <= seq_count_d;
      qual_count_q <= qual_count_d;
      ovf_q        <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (accept && res_valid) begin
      if (out_valid_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.end_of_stream;
  assign m_axis_tdata  = {6'd0, out_q.seq_length, out_q.status, out_q.char_value};

  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid entry is valid while the output register is empty.");

  a_qual_le_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qual_count_q <= seq_count_q)
    else $error("Quality count exceeds sequence count.");

  a_seek_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ffrp_pkg::PhSeek) |-> (seq_count_q == '0 && qual_count_q == '0 && !ovf_q))
    else $error("Record counters are not clear while seeking a header.");

  a_char_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind != ffrp_pkg::KindRecord)
      |-> (out_q.seq_length == '0 && out_q.status == ffrp_pkg::StFasta))
    else $error("Non-record result carries a status or a length.");

  a_stream_end_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (phase_q == ffrp_pkg::PhSeek))
    else $error("Parser did not return to header seek after stream end.");

endmodule
